>>> design/deq_pkg.sv
// shared types and codes for the double-ended queue
// no dependencies; used by deq_ctrl, deq_datapath and double_ended_queue_top
package deq_pkg;

  // fixed field widths
  localparam int REQ_W  = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] OP_SIZE      = 3'd4;
  localparam logic [REQ_W-1:0] OP_EMPTY     = 3'd5;
  localparam logic [REQ_W-1:0] OP_FRONT     = 3'd6;
  localparam logic [REQ_W-1:0] OP_BACK      = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic update;    // apply the accepted request, start memory read
    logic load_mem;  // capture the memory read word into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic out_valid;
  } dp_status_t;

endpackage

>>> design/deq_ctrl.sv
// controller state machine for the double-ended queue
// depends on deq_pkg
module deq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [deq_pkg::REQ_W-1:0]   req_type,
  input  logic                        out_ready,
  input  deq_pkg::dp_status_t         stat,
  output logic                        in_ready,
  output deq_pkg::ctrl_cmd_t          cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic needs_read;

  // pops and peeks on a non-empty store wait in S_READ for the registered memory word
  always_comb begin
    unique case (req_type)
      deq_pkg::OP_DEL_FRONT, deq_pkg::OP_DEL_BACK,
      deq_pkg::OP_FRONT, deq_pkg::OP_BACK: needs_read = !stat.empty;
      default:                             needs_read = 1'b0;
    endcase
  end

  // take a beat only when the output register will be free
  assign in_ready     = (state == S_IDLE) && (!stat.out_valid || out_ready);
  assign cmd.update   = in_ready && in_valid;
  assign cmd.load_mem = (state == S_READ);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.update && needs_read) state_next = S_READ;
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/deq_datapath.sv
// datapath of the double-ended queue: ring memory, indices, count, output register
// depends on deq_pkg
module deq_datapath #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::ctrl_cmd_t                cmd,
  input  logic [deq_pkg::REQ_W-1:0]         req_type,
  input  logic signed [deq_pkg::WORD_W-1:0] push_value,
  input  logic                              out_ready,
  output deq_pkg::dp_status_t               stat,
  output logic signed [deq_pkg::WORD_W-1:0] result_value,
  output logic [deq_pkg::STAT_W-1:0]        status
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             out_valid;

  logic [IDX_W-1:0] head_prev;
  logic [IDX_W-1:0] head_succ;
  logic [IDX_W-1:0] tail_prev;
  logic [IDX_W-1:0] tail_succ;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             empty;
  logic             full;
  logic             is_push;
  logic             do_write;
  logic             imm_valid;
  logic signed [deq_pkg::WORD_W-1:0] imm_value;
  logic [deq_pkg::STAT_W-1:0]        imm_status;
  logic signed [DATA_WIDTH-1:0]      push_word;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  // ring index neighbors
  assign head_prev = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_succ = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_prev = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign tail_succ = (tail == LAST_IDX) ? '0 : tail + 1'b1;

  assign push_word = DATA_WIDTH'(push_value);
  assign is_push   = (req_type == deq_pkg::OP_INS_FRONT) ||
                     (req_type == deq_pkg::OP_INS_BACK);
  assign do_write  = cmd.update && is_push && !full;
  assign wr_addr   = (req_type == deq_pkg::OP_INS_FRONT) ? head_prev : tail;
  assign rd_addr   = ((req_type == deq_pkg::OP_DEL_FRONT) ||
                      (req_type == deq_pkg::OP_FRONT)) ? head : tail_prev;

  // results known in the accept cycle
  always_comb begin
    imm_valid  = 1'b0;
    imm_value  = '0;
    imm_status = deq_pkg::ST_OK;
    unique case (req_type)
      deq_pkg::OP_INS_FRONT, deq_pkg::OP_INS_BACK: begin
        imm_valid  = full;
        imm_status = deq_pkg::ST_FULL;
      end
      deq_pkg::OP_SIZE: begin
        imm_valid = 1'b1;
        imm_value = deq_pkg::WORD_W'(count);
      end
      deq_pkg::OP_EMPTY: begin
        imm_valid = 1'b1;
        imm_value = deq_pkg::WORD_W'(empty);
      end
      default: begin
        imm_valid  = empty;
        imm_value  = '1;
        imm_status = deq_pkg::ST_EMPTY;
      end
    endcase
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= push_word;
    end
    if (cmd.update) begin
      rdata <= mem[rd_addr];
    end
  end

  // indices and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.update) begin
      unique case (req_type)
        deq_pkg::OP_INS_FRONT: if (!full) begin
          head  <= head_prev;
          count <= count + 1'b1;
        end
        deq_pkg::OP_INS_BACK: if (!full) begin
          tail  <= tail_succ;
          count <= count + 1'b1;
        end
        deq_pkg::OP_DEL_FRONT: if (!empty) begin
          head  <= head_succ;
          count <= count - 1'b1;
        end
        deq_pkg::OP_DEL_BACK: if (!empty) begin
          tail  <= tail_prev;
          count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.update && imm_valid) || cmd.load_mem) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      result_value <= deq_pkg::WORD_W'(rdata);
      status       <= deq_pkg::ST_OK;
    end else if (cmd.update && imm_valid) begin
      result_value <= imm_value;
      status       <= imm_status;
    end
  end

  assign stat.empty     = empty;
  assign stat.out_valid = out_valid;

endmodule

>>> design/double_ended_queue_top.sv
// bounded double-ended queue over a ring memory; depends on deq_pkg, deq_ctrl, deq_datapath
// one request beat in, at most one result beat out; pushes, pops and queries
// size, empty, full push and empty pop/peek results go straight to the output register;
// pops and peeks that read a word go through the registered memory read and S_READ
// throughput: one request per cycle for pushes and queries; a word read blocks new requests
// until its word is loaded. a stalled result blocks new requests. sync reset empties the queue
module double_ended_queue_top #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_value
  output logic [1:0]  m_tuser    // [1:0] status
);

  deq_pkg::ctrl_cmd_t  cmd;
  deq_pkg::dp_status_t stat;
  logic signed [deq_pkg::WORD_W-1:0] result_value;

  // controller
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .req_type  (s_tuser),
    .out_ready (m_tready),
    .stat      (stat),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  // datapath
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (s_tuser),
    .push_value   (s_tdata),
    .out_ready    (m_tready),
    .stat         (stat),
    .result_value (result_value),
    .status       (m_tuser)
  );

  assign m_tvalid = stat.out_valid;
  assign m_tdata  = result_value;

endmodule
